### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion wrappers, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define LNH_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true outside reset
`define LNH_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

### rtl/lnh_pkg.sv
// ----------------------------------------------------------------------------
// lnh_pkg
// shared widths, constants, register codes and command type of the
// note heat histogram
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lnh_pkg;

	localparam int HEAT_W    = 28;
	localparam int LOSS_W    = 14;
	localparam int IDX_W     = 4;
	localparam int RD_W      = 5;
	localparam int CNT_W     = 6;
	localparam int CFG_IDX_W = 1;
	localparam int IN_W      = 16;
	localparam int OUT_W     = 56;

	// 10.0 in q4.24
	localparam logic [HEAT_W-1:0] FULL_SCALE = 28'd167772160;
	localparam logic [HEAT_W-1:0] GAIN_RESET = 28'd838861;
	localparam logic [LOSS_W-1:0] LOSS_RESET = 14'd168;
	localparam logic [IDX_W-1:0]  OCT_OFFSET = 4'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEAT_GAIN = 1'b0,
		REG_HEAT_LOSS = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic             load;
		logic             run;
		logic [CNT_W-1:0] idx;
		logic             finish;
	} lnh_cmd_t;

endpackage

### rtl/lnh_datapath.sv
// ----------------------------------------------------------------------------
// lnh_datapath
// ring of heat bins walked through one update unit, running statistics
// and result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lnh_datapath import lnh_pkg::*; #(
	parameter int SEMITONE_BINS = 12,
	parameter int OCTAVE_BINS   = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lnh_cmd_t                 cmd,
	input  logic                     cfg_wr,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [HEAT_W-1:0]        cfg_data,
	input  logic                     gate_level,
	input  logic [IDX_W-1:0]         note_index,
	input  logic [IDX_W-1:0]         octave_index,
	input  logic                     clear_all,
	input  logic [RD_W-1:0]          read_bin,
	output logic [IDX_W-1:0]         warmest_semitone,
	output logic [IDX_W-1:0]         coolest_semitone,
	output logic signed [IDX_W-1:0]  warmest_octave,
	output logic signed [IDX_W-1:0]  coolest_octave,
	output logic                     any_heat,
	output logic                     note_changed,
	output logic [IDX_W-1:0]         changed_semitone,
	output logic [HEAT_W-1:0]        bin_level
);

	localparam int NUM_BINS = SEMITONE_BINS + OCTAVE_BINS;
	localparam int SIDX_W   = $clog2(SEMITONE_BINS);
	localparam logic [CNT_W-1:0] SEMI_END = CNT_W'(SEMITONE_BINS);
	localparam logic [CNT_W-1:0] BIN_END  = CNT_W'(NUM_BINS);

	logic [HEAT_W-1:0] gain_q;
	logic [LOSS_W-1:0] loss_q;

	logic                     gate_prev_q, edge_q, clear_q, first_q;
	logic [IDX_W-1:0]         note_q, oct_q;
	logic [RD_W-1:0]          rd_q;
	logic [SEMITONE_BINS-1:0] prior_q, nz_q;

	logic [HEAT_W-1:0] bins_q [NUM_BINS];
	logic [HEAT_W-1:0] heat_s1, heat_s2;
	logic [CNT_W-1:0]  idx_s1, idx_s2;
	logic              vld_s1, vld_s2;

	logic [HEAT_W-1:0] sw_best_q, sc_best_q, ow_best_q, oc_best_q, level_q;
	logic [IDX_W-1:0]  sw_idx_q, sc_idx_q, ow_idx_q, oc_idx_q, chg_idx_q;
	logic              sw_any_q, sc_found_q, ow_found_q, oc_found_q, chg_q;

	logic [IDX_W-1:0]  held_warm_q, held_cool_q, held_chg_q;
	logic [IDX_W-1:0]  wo_q, co_q;
	logic              any_q, changed_q;
	logic [HEAT_W-1:0] level_out_q;

	// stage 1: gain on a rising gate for the bin at the head of the ring
	logic [CNT_W-1:0]  oct_pos;
	logic              is_semi, is_real, hit;
	logic [HEAT_W-1:0] head, sat, heat_next;
	logic [HEAT_W:0]   sum;

	always_comb begin
		head    = bins_q[0];
		oct_pos = cmd.idx - SEMI_END;
		is_semi = cmd.idx < SEMI_END;
		is_real = cmd.idx < BIN_END;
		hit     = edge_q && (is_semi ? (cmd.idx == CNT_W'(note_q))
		                             : (is_real && oct_pos == CNT_W'(oct_q)));
		sum     = {1'b0, head} + {1'b0, gain_q};
		if (head < FULL_SCALE) begin
			sat = (sum > {1'b0, FULL_SCALE}) ? FULL_SCALE : sum[HEAT_W-1:0];
		end else begin
			sat = (head > FULL_SCALE) ? FULL_SCALE : head;
		end
		heat_next = hit ? sat : head;
	end

	// stage 2: decay floored at zero, or clear
	logic [HEAT_W-1:0] loss_ext, decayed;

	always_comb begin
		loss_ext = HEAT_W'(loss_q);
		if (clear_q) begin
			decayed = '0;
		end else begin
			decayed = (heat_s1 > loss_ext) ? heat_s1 - loss_ext : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			loss_q <= LOSS_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_HEAT_GAIN: gain_q <= cfg_data;
				REG_HEAT_LOSS: loss_q <= cfg_data[LOSS_W-1:0];
				default: ;
			endcase
		end
	end

	// input word capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_prev_q <= 1'b1;
			edge_q      <= 1'b0;
		end else if (cmd.load) begin
			edge_q      <= gate_level & ~gate_prev_q;
			gate_prev_q <= gate_level;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			clear_q <= clear_all;
			note_q  <= note_index;
			oct_q   <= octave_index;
			rd_q    <= read_bin;
		end
	end

	// ring plus stage 1 register form a loop of NUM_BINS+1 places
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BINS; i++) begin
				bins_q[i] <= '0;
			end
			heat_s1 <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
		end else begin
			vld_s1 <= cmd.run && is_real;
			vld_s2 <= cmd.run && vld_s1;
			if (cmd.run) begin
				for (int i = 0; i < NUM_BINS - 1; i++) begin
					bins_q[i] <= bins_q[i+1];
				end
				bins_q[NUM_BINS-1] <= decayed;
				heat_s1            <= heat_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.run) begin
			idx_s1  <= cmd.idx;
			idx_s2  <= idx_s1;
			heat_s2 <= decayed;
		end
	end

	// stage 3: running statistics over the decayed bins
	logic             s_semi, s_real, d_nz;
	logic [CNT_W-1:0] s_opos;

	always_comb begin
		s_semi = idx_s2 < SEMI_END;
		s_real = idx_s2 < BIN_END;
		s_opos = idx_s2 - SEMI_END;
		d_nz   = heat_s2 != '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sw_best_q  <= '0;
			sw_any_q   <= 1'b0;
			sc_best_q  <= FULL_SCALE;
			sc_found_q <= 1'b0;
			ow_best_q  <= '0;
			ow_found_q <= 1'b0;
			oc_best_q  <= FULL_SCALE;
			oc_found_q <= 1'b0;
			chg_q      <= 1'b0;
			level_q    <= '0;
		end else if (vld_s2) begin
			if (idx_s2 == CNT_W'(rd_q)) begin
				level_q <= heat_s2;
			end
			if (s_semi) begin
				nz_q <= {d_nz, nz_q[SEMITONE_BINS-1:1]};
				if (heat_s2 > sw_best_q) begin
					sw_best_q <= heat_s2;
					sw_idx_q  <= idx_s2[IDX_W-1:0];
					sw_any_q  <= 1'b1;
				end
				if (d_nz && heat_s2 < sc_best_q) begin
					sc_best_q  <= heat_s2;
					sc_idx_q   <= idx_s2[IDX_W-1:0];
					sc_found_q <= 1'b1;
				end
				// later hits overwrite, so the highest index stays
				if (!first_q && (d_nz != prior_q[idx_s2[SIDX_W-1:0]])) begin
					chg_q     <= 1'b1;
					chg_idx_q <= idx_s2[IDX_W-1:0];
				end
			end else if (s_real) begin
				if (heat_s2 > ow_best_q) begin
					ow_best_q  <= heat_s2;
					ow_idx_q   <= s_opos[IDX_W-1:0];
					ow_found_q <= 1'b1;
				end
				if (d_nz && heat_s2 < oc_best_q) begin
					oc_best_q  <= heat_s2;
					oc_idx_q   <= s_opos[IDX_W-1:0];
					oc_found_q <= 1'b1;
				end
			end
		end
	end

	// end of pass: fold into held state and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_warm_q <= '0;
			held_cool_q <= '0;
			held_chg_q  <= '0;
			first_q     <= 1'b1;
			prior_q     <= '0;
		end else if (cmd.finish) begin
			if (sw_any_q) begin
				held_warm_q <= sw_idx_q;
			end
			if (sc_found_q) begin
				held_cool_q <= sc_idx_q;
			end
			if (chg_q) begin
				held_chg_q <= chg_idx_q;
			end
			first_q <= 1'b0;
			prior_q <= nz_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			wo_q        <= ow_found_q ? ow_idx_q - OCT_OFFSET : '0;
			co_q        <= oc_found_q ? oc_idx_q - OCT_OFFSET : '0;
			any_q       <= sw_any_q;
			changed_q   <= chg_q;
			level_out_q <= level_q;
		end
	end

	assign warmest_semitone = held_warm_q;
	assign coolest_semitone = held_cool_q;
	assign warmest_octave   = wo_q;
	assign coolest_octave   = co_q;
	assign any_heat         = any_q;
	assign note_changed     = changed_q;
	assign changed_semitone = held_chg_q;
	assign bin_level        = level_out_q;

	`LNH_ASSERT_NEVER(a_bin_bound, bins_q[0] > FULL_SCALE, "heat bin above full scale")
	`LNH_ASSERT_NEVER(a_warm_range, 5'(held_warm_q) >= 5'(SEMITONE_BINS), "warmest index out of range")
	`LNH_ASSERT_CLK(a_stage_order, vld_s2 |-> $past(vld_s1), "stage 2 valid without stage 1")

endmodule

### rtl/lnh_ctrl.sv
// ----------------------------------------------------------------------------
// lnh_ctrl
// sequencer: accepts a word, steps the bin pass, hands the result to the
// output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lnh_ctrl import lnh_pkg::*; #(
	parameter int NUM_BINS = 22
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output lnh_cmd_t cmd
);

	localparam logic [CNT_W-1:0] LAST_RUN = CNT_W'(NUM_BINS);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_BINS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PASS,
		ST_FINISH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             m_tvalid_q;
	logic             out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd.load   = s_tvalid && state_q == ST_IDLE;
		cmd.run    = state_q == ST_PASS && cnt_q <= LAST_RUN;
		cmd.idx    = cnt_q;
		cmd.finish = state_q == ST_FINISH && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_PASS;
						cnt_q   <= '0;
					end
				end
				ST_PASS: begin
					// the counts after the last bin, up to LAST_CNT, drain the decay and statistics stages
					if (cnt_q == LAST_CNT) begin
						state_q <= ST_FINISH;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`LNH_ASSERT_NEVER(a_cnt_range, state_q == ST_PASS && cnt_q > LAST_CNT, "pass count overrun")
	`LNH_ASSERT_CLK(a_valid_src, $rose(m_tvalid_q) |-> $past(state_q == ST_FINISH), "word raised outside finish")
	`LNH_ASSERT_NEVER(a_finish_blocked, cmd.finish && m_tvalid_q && !m_tready, "result overwritten while stalled")

endmodule

### rtl/leaky_note_heat_histogram_core.sv
// ----------------------------------------------------------------------------
// leaky_note_heat_histogram_core
// leaky semitone and octave heat histogram with warmest/coolest tracking
// ----------------------------------------------------------------------------
// Each accepted input word is one sample tick and yields exactly one result
// word. In a tick all bins sit in one ring that rotates through a single
// gain/decay unit, one bin per cycle, followed by a statistics stage and a
// finish step that loads the result. A new word is not taken while a pass
// runs; it can be accepted from the same cycle in which the result is offered,
// even while that result still waits in the output register. A result still
// waiting when the following pass ends holds that pass, and the input, until
// it is taken.
// Bins come out of reset at zero with no clearing pass.
// Configuration writes (index 0 heat_gain, index 1 heat_loss) are always
// accepted and belong between ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module leaky_note_heat_histogram_core import lnh_pkg::*; #(
	parameter int SEMITONE_BINS = 12,
	parameter int OCTAVE_BINS   = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// gate_level, note_index[3:0], octave_index[3:0], clear_all, read_bin[4:0]
	input  logic [IN_W-1:0]      s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// warmest_semitone[3:0], coolest_semitone[3:0], warmest_octave[3:0],
	// coolest_octave[3:0], any_heat, note_changed, changed_semitone[3:0],
	// bin_level[27:0]
	output logic [OUT_W-1:0]     m_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [HEAT_W-1:0]    cfg_data
);

	localparam int NUM_BINS = SEMITONE_BINS + OCTAVE_BINS;

	lnh_cmd_t cmd;

	logic [IDX_W-1:0]        warmest_semitone, coolest_semitone, changed_semitone;
	logic signed [IDX_W-1:0] warmest_octave, coolest_octave;
	logic                    any_heat, note_changed;
	logic [HEAT_W-1:0]       bin_level;

	assign cfg_ready = 1'b1;

	lnh_ctrl #(
		.NUM_BINS (NUM_BINS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	lnh_datapath #(
		.SEMITONE_BINS (SEMITONE_BINS),
		.OCTAVE_BINS   (OCTAVE_BINS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg_wr           (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.gate_level       (s_tdata[0]),
		.note_index       (s_tdata[4:1]),
		.octave_index     (s_tdata[8:5]),
		.clear_all        (s_tdata[9]),
		.read_bin         (s_tdata[14:10]),
		.warmest_semitone (warmest_semitone),
		.coolest_semitone (coolest_semitone),
		.warmest_octave   (warmest_octave),
		.coolest_octave   (coolest_octave),
		.any_heat         (any_heat),
		.note_changed     (note_changed),
		.changed_semitone (changed_semitone),
		.bin_level        (bin_level)
	);

	assign m_tdata = {6'b0, bin_level, changed_semitone, note_changed, any_heat,
	                  coolest_octave, warmest_octave, coolest_semitone,
	                  warmest_semitone};

endmodule
